// ===== rtl/core/sipq_pkg.sv =====
// Shared constants and control types of the sorted-insert priority queue.
// No dependencies; every other file in this folder imports this package.
package sipq_pkg;

  // Built size defaults, handed down to the top-level parameters.
  localparam int DEF_DEPTH     = 16;
  localparam int DEF_TIME_BITS = 16;
  localparam int DEF_CNT_W     = $clog2(DEF_DEPTH + 1);

  // Fixed field widths of the request and result channels.
  localparam int TIME_IN_W = 16;
  localparam int TAG_W     = 8;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;     // capture an accepted request
    logic               rd_head;  // read the head slot
    logic               rd_prev;  // read the slot just before the insert position
    logic               shift;    // move the read entry up one slot
    logic               place;    // write the new entry at the insert position
    logic               pop;      // retire the head entry
    logic               emit;     // load the result register
    logic [STAT_W-1:0]  code;     // status reported with the result
  } sipq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_deq;      // held request is a dequeue
    logic full;        // entry count has reached the effective capacity
    logic empty;       // no entries held
    logic pos_one;     // insert position is one slot past the head
    logic rd_greater;  // read entry time is greater than the new time
    logic out_free;    // result register can take a new result
  } sipq_sts_t;

endpackage

// ===== rtl/core/sipq_in_if.sv =====
// Request channel of the priority queue: valid/ready handshake plus payload.
// Depends on sipq_pkg for the field widths.
interface sipq_in_if;
  import sipq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [TIME_IN_W-1:0] entry_time;
  logic [TAG_W-1:0]     entry_tag;

  modport source (output valid, output operation, output entry_time, output entry_tag,
                  input ready);
  modport sink   (input valid, input operation, input entry_time, input entry_tag,
                  output ready);
endinterface

// ===== rtl/core/sipq_out_if.sv =====
// Result channel of the priority queue: valid/ready handshake plus payload.
// Depends on sipq_pkg for the field widths and the default count width.
interface sipq_out_if #(
  parameter int CNT_W = sipq_pkg::DEF_CNT_W
);
  import sipq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TIME_IN_W-1:0] out_time;
  logic [TAG_W-1:0]     out_tag;
  logic [STAT_W-1:0]    status;
  logic [CNT_W-1:0]     entry_count;

  modport source (output valid, output out_time, output out_tag, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input out_time, input out_tag, input status,
                  input entry_count, output ready);
endinterface

// ===== rtl/core/sipq_datapath.sv =====
// Datapath of the priority queue: circular entry store, head and count,
// insert position, capacity register and the result register.
// Depends on sipq_pkg and sipq_out_if.
module sipq_datapath #(
  parameter int DEPTH     = sipq_pkg::DEF_DEPTH,
  parameter int TIME_BITS = sipq_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          operation,
  input  logic [sipq_pkg::TIME_IN_W-1:0] entry_time,
  input  logic [sipq_pkg::TAG_W-1:0]    entry_tag,
  input  logic                          cfg_we,
  input  logic [sipq_pkg::CAP_W-1:0]    cfg_wdata,
  input  sipq_pkg::sipq_cmd_t           cmd,
  output sipq_pkg::sipq_sts_t           sts,
  sipq_out_if.source                    out_chan
);
  import sipq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEEP  = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;
  localparam int ENT_W = TIME_BITS + TAG_W;

  // Entry store; reset leaves it undefined.
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic                 op_r;
  logic [TIME_BITS-1:0] time_r;
  logic [TAG_W-1:0]     tag_r;

  logic                 out_valid_r;
  logic [TIME_IN_W-1:0] out_time_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [CNT_W-1:0]     out_count_r;

  logic [TIME_BITS-1:0] new_time;
  logic [TIME_BITS-1:0] rd_time;
  logic [TAG_W-1:0]     rd_tag;
  logic [TIME_IN_W-1:0] rd_time_out;
  logic [CW-1:0]        eff_cap;
  logic [CNT_W-1:0]     prev_off;
  logic [IDX_W-1:0]     wr_addr, rd_addr, prev_slot, next_head;
  logic                 rd_en, wr_en;
  logic [ENT_W-1:0]     wr_data;

  // Circular slot of an offset from the head; the sum stays below twice DEPTH.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  always_comb begin
    new_time = '0;
    new_time[KEEP-1:0] = entry_time[KEEP-1:0];
  end

  assign rd_time = rd_data_r[ENT_W-1:TAG_W];
  assign rd_tag  = rd_data_r[TAG_W-1:0];

  always_comb begin
    rd_time_out = '0;
    rd_time_out[KEEP-1:0] = rd_time[KEEP-1:0];
  end

  // Capacity zero acts as one; capacity above the built depth saturates.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_r) > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  // When shifting, the next compare reads one slot further down.
  assign prev_off  = pos_r - CNT_W'(1) - CNT_W'(cmd.shift);
  assign prev_slot = slot_of(head_r, prev_off);
  assign next_head = slot_of(head_r, CNT_W'(1));

  assign wr_addr = slot_of(head_r, pos_r);
  assign wr_en   = cmd.shift | cmd.place;
  assign wr_data = cmd.shift ? rd_data_r : {time_r, tag_r};
  assign rd_en   = cmd.rd_head | cmd.rd_prev;
  assign rd_addr = cmd.rd_head ? head_r : prev_slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    if (cmd.load) begin
      pos_nxt = count_r;
    end
    if (cmd.shift) begin
      pos_nxt = pos_r - CNT_W'(1);
    end
    if (cmd.place) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.pop) begin
      head_nxt  = next_head;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      out_valid_r <= cmd.emit | (out_valid_r & ~out_chan.ready);
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= operation;
      time_r <= new_time;
      tag_r  <= entry_tag;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      out_count_r  <= count_r;
      if (op_r == OP_DEQ && cmd.code == STAT_DONE) begin
        out_time_r <= rd_time_out;
        out_tag_r  <= rd_tag;
      end else begin
        out_time_r <= '0;
        out_tag_r  <= '0;
      end
    end
  end

  always_comb begin
    sts.is_deq     = (op_r == OP_DEQ);
    sts.full       = (CW'(count_r) >= eff_cap);
    sts.empty      = (count_r == '0);
    sts.pos_one    = (pos_r == CNT_W'(1));
    sts.rd_greater = (rd_time > time_r);
    sts.out_free   = ~out_valid_r | out_chan.ready;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_time    = out_time_r;
  assign out_chan.out_tag     = out_tag_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_count = out_count_r;

endmodule

// ===== rtl/core/sipq_ctrl.sv =====
// Controller of the priority queue: sequences one request at a time through
// the datapath. Depends on sipq_pkg for the command and status types.
module sipq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sipq_pkg::sipq_sts_t sts,
  output sipq_pkg::sipq_cmd_t cmd
);
  import sipq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_PLACE,
    S_POP,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [STAT_W-1:0] code_r, code_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.code  = code_r;
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        code_nxt = STAT_DONE;
        if (sts.is_deq) begin
          if (sts.empty) begin
            code_nxt  = STAT_EMPTY;
            state_nxt = S_FINISH;
          end else begin
            cmd.rd_head = 1'b1;
            state_nxt   = S_POP;
          end
        end else if (sts.full) begin
          code_nxt  = STAT_FULL;
          state_nxt = S_FINISH;
        end else if (sts.empty) begin
          cmd.place = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        // A later time moves up one slot; otherwise the new entry goes here.
        if (sts.rd_greater) begin
          cmd.shift = 1'b1;
          if (sts.pos_one) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_prev = 1'b1;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FINISH;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= STAT_DONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// Sorted-insert priority queue of (time, tag) entries in a circular store.
// A rejected enqueue or an empty dequeue goes straight to finish, a dequeue via the pop
// state; an enqueue on an empty queue is placed at once, any other walks the compare
// state, where k entries (at most DEPTH - 1) move up one slot, one per cycle, each read
// and write together, before the new entry is placed. Throughput: one request at a time;
// the next is taken in the cycle after the result is loaded, later while a held result
// waits. Reset (synchronous, rst_n low): queue empty, head at slot zero, capacity 16.
module sorted_insert_priority_queue #(
  parameter int DEPTH     = sipq_pkg::DEF_DEPTH,
  parameter int TIME_BITS = sipq_pkg::DEF_TIME_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sipq_in_if.sink                    in_chan,
  sipq_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [sipq_pkg::CAP_W-1:0] cfg_wdata
);
  import sipq_pkg::*;

  // The controller and the datapath talk only through these two structs.
  sipq_cmd_t cmd;
  sipq_sts_t sts;
  logic      in_ready;

  // A request is taken only while the controller waits in its idle state.
  // The result register in the datapath lets the next request in even while
  // the previous result has not yet been taken downstream.
  assign in_chan.ready = in_ready;

  sipq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the entry store, the head slot, the entry count, the
  // capacity register and the result register. An enqueue walks down from
  // the tail, moving each entry with a later time up one slot, and then
  // writes the new entry, so equal times keep their arrival order.
  sipq_datapath #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .operation  (in_chan.operation),
    .entry_time (in_chan.entry_time),
    .entry_tag  (in_chan.entry_tag),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_chan   (out_chan)
  );

endmodule
